// ===== src/lru_key_value_cache_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Clocked assertion shorthands shared by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define LRUKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the next rising clk edge outside of reset.
`define LRUKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared defaults, command codes and the per-cell control struct.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int ENTRIES_DEF    = 8;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FIELD_BITS = 32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic cmp;
    logic take;
  } cell_ctl_t;

endpackage

// ===== src/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative get/put store; a chain of cells ordered by recency, head
// most recent, tail the replacement victim.
// Flow: accept registers the request and the key compare; the chain update then
// registers the result, held off while an earlier result waits under out_stall.
// No new transaction is accepted until the chain update of the last one is done.
// Reset: synchronous; all entries invalid, no result pending.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
  parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] lookup_key,
  input  logic [31:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] read_value,
  output logic        evicted
);

  localparam int FB = lrukv_pkg::FIELD_BITS;
  localparam logic [ENTRIES-1:0] ENT_ONE = {{(ENTRIES-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t state, state_next;

  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [KEY_BITS-1:0]   key_port;
  logic [VALUE_BITS-1:0] val_port;

  logic [KEY_BITS-1:0]   c_key   [ENTRIES];
  logic [VALUE_BITS-1:0] c_value [ENTRIES];
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    lower_hit;
  lrukv_pkg::cell_ctl_t  ctl [ENTRIES];

  logic                  in_acc, out_acc, commit, hit, is_put;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS-1:0] head_value;
  logic [FB-1:0]         hit_value_fb;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign commit   = (state == S_UPD) && !(out_valid && out_stall);
  assign hit      = |match_vec;
  assign is_put   = (cmd_q == lrukv_pkg::CMD_PUT);

  generate
    if (KEY_BITS > FB) begin : g_key_ext
      assign key_port = {{(KEY_BITS-FB){1'b0}}, lookup_key};
    end else begin : g_key_trunc
      assign key_port = lookup_key[KEY_BITS-1:0];
    end
    if (VALUE_BITS > FB) begin : g_val_wide
      assign val_port     = {{(VALUE_BITS-FB){1'b0}}, write_value};
      assign hit_value_fb = hit_value[FB-1:0];
    end else if (VALUE_BITS == FB) begin : g_val_same
      assign val_port     = write_value;
      assign hit_value_fb = hit_value;
    end else begin : g_val_narrow
      assign val_port     = write_value[VALUE_BITS-1:0];
      assign hit_value_fb = {{(FB-VALUE_BITS){1'b0}}, hit_value};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q <= cmd;
      key_q <= key_port;
      val_q <= val_port;
    end
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | c_value[i];
      end
    end
  end

  assign head_value = is_put ? val_q : hit_value;

  generate
    for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
      if (p == 0) begin : g_head
        assign lower_hit[p] = 1'b0;
        assign ctl[p].take  = commit && (hit || is_put);
        lrukv_cell #(
          .KEY_BITS   (KEY_BITS),
          .VALUE_BITS (VALUE_BITS)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl[p]),
          .cmp_key  (key_port),
          .in_key   (key_q),
          .in_value (head_value),
          .in_valid (1'b1),
          .key      (c_key[p]),
          .value    (c_value[p]),
          .valid    (valid_vec[p]),
          .match    (match_vec[p])
        );
      end else begin : g_body
        assign lower_hit[p] = |match_vec[p-1:0];
        assign ctl[p].take  = commit && (hit ? !lower_hit[p] : is_put);
        lrukv_cell #(
          .KEY_BITS   (KEY_BITS),
          .VALUE_BITS (VALUE_BITS)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctl      (ctl[p]),
          .cmp_key  (key_port),
          .in_key   (c_key[p-1]),
          .in_value (c_value[p-1]),
          .in_valid (valid_vec[p-1]),
          .key      (c_key[p]),
          .value    (c_value[p]),
          .valid    (valid_vec[p]),
          .match    (match_vec[p])
        );
      end
      assign ctl[p].cmp = in_acc;
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found      <= hit;
      read_value <= (hit && !is_put) ? hit_value_fb : '0;
      evicted    <= is_put && !hit && valid_vec[ENTRIES-1];
    end
  end

  `LRUKV_ASSERT(a_match_onehot, $onehot0(match_vec), "more than one cell matched the key")
  `LRUKV_ASSERT(a_valid_packed, ((valid_vec + ENT_ONE) & valid_vec) == '0,
                "valid entries are not packed at the head of the chain")
  `LRUKV_ASSERT(a_no_evict_on_hit, !(out_valid && found && evicted),
                "result reports both a hit and an eviction")
  `LRUKV_ASSERT_NEXT(a_result_follows, commit, out_valid && (state == S_IDLE),
                     "chain update did not produce a result")

endmodule

// ===== src/lrukv_cell.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One entry of the recency chain: holds key, value and valid, registers its
// key match, and loads either its upstream neighbor or the head data.
// ----------------------------------------------------------------------------
module lrukv_cell #(
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrukv_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_valid,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  valid,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      key   <= in_key;
      value <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.take) begin
        valid <= in_valid;
      end
      if (ctl.cmp) begin
        match <= valid && (key == cmp_key);
      end
    end
  end

endmodule

// ===== tb/lru_cache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Watches both channels of the cache. Each accepted request runs through a
// cycle-free model of the LRU store, and the predicted reply is queued. Each
// accepted reply is checked field by field against the oldest prediction.
// Reports the error count and the number of replies still outstanding.
// ----------------------------------------------------------------------------
module lru_cache_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] lookup_key,
  input  logic [31:0] write_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        found,
  input  logic [31:0] read_value,
  input  logic        evicted,
  output int          mismatch_count,
  output int          pending_count
);

  localparam int N  = lrukv_pkg::ENTRIES_DEF;
  localparam int RW = $clog2(N);
  localparam int KB = lrukv_pkg::KEY_BITS_DEF;
  localparam int VB = lrukv_pkg::VALUE_BITS_DEF;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
  } reply_t;

  logic [KB-1:0]   tag_mem  [N];
  logic [VB-1:0]   data_mem [N];
  logic            line_valid [N];
  logic [RW-1:0]   age_rank [N];

  reply_t expected_replies[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic make_recent(input int e);
    logic [RW-1:0] r;
    r = age_rank[e];
    for (int j = 0; j < N; j++) begin
      if (age_rank[j] < r) age_rank[j] = age_rank[j] + 1'b1;
    end
    age_rank[e] = '0;
  endtask

  task automatic cache_access(input logic c, input logic [31:0] k, input logic [31:0] v,
                              output reply_t r);
    int   hit;
    int   victim;
    logic hit_any;
    hit     = 0;
    hit_any = 1'b0;
    r       = '0;
    // lowest matching index wins
    for (int i = N - 1; i >= 0; i--) begin
      if (line_valid[i] && tag_mem[i] == k[KB-1:0]) begin
        hit     = i;
        hit_any = 1'b1;
      end
    end
    r.found = hit_any;
    if (hit_any) begin
      if (c == lrukv_pkg::CMD_GET) r.read_value = 32'(data_mem[hit]);
      else data_mem[hit] = v[VB-1:0];
      make_recent(hit);
    end else if (c == lrukv_pkg::CMD_PUT) begin
      victim = 0;
      for (int i = N - 1; i >= 0; i--) begin
        if (age_rank[i] == N - 1) victim = i;
      end
      r.evicted          = line_valid[victim];
      tag_mem[victim]    = k[KB-1:0];
      data_mem[victim]   = v[VB-1:0];
      line_valid[victim] = 1'b1;
      make_recent(victim);
    end
  endtask

  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    reply_t pred;
    if (rst) begin
      expected_replies.delete();
      for (int i = 0; i < N; i++) begin
        line_valid[i] = 1'b0;
        age_rank[i]   = RW'(i);
      end
    end else begin
      if (out_valid && !out_stall) begin
        got.found      = found;
        got.read_value = read_value;
        got.evicted    = evicted;
        if (expected_replies.size() == 0) begin
          flag_error($sformatf("reply with none outstanding: found=%b read_value=%h evicted=%b",
                               got.found, got.read_value, got.evicted));
        end else begin
          want = expected_replies.pop_front();
          if (got.found !== want.found || got.read_value !== want.read_value ||
              got.evicted !== want.evicted) begin
            flag_error($sformatf({"reply mismatch: expected found=%b read_value=%h evicted=%b,",
                                  " got found=%b read_value=%h evicted=%b"},
                                 want.found, want.read_value, want.evicted,
                                 got.found, got.read_value, got.evicted));
          end
        end
      end
      if (in_valid && !in_stall) begin
        cache_access(cmd, lookup_key, write_value, pred);
        expected_replies.push_back(pred);
      end
    end
    pending_count = expected_replies.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get/put transactions into the cache: a directed opening covering
// empty misses, key and value extremes, updates, fills and evictions, then
// random traffic over small key pools so hits, updates and evictions are
// frequent. Both channels idle in random bursts; the checker scores replies.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1930;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        cmd         = lrukv_pkg::CMD_GET;
  logic [31:0] lookup_key  = '0;
  logic [31:0] write_value = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        found;
  logic [31:0] read_value;
  logic        evicted;

  int          err_count;
  int          pending;
  bit          idle_en     = 1'b1;
  int          stall_left  = 0;
  int          quiet_cycles;
  logic [31:0] hot_keys  [12];
  logic [31:0] warm_keys [32];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .lookup_key (lookup_key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .evicted    (evicted)
  );

  lru_cache_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .lookup_key    (lookup_key),
    .write_value   (write_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .read_value    (read_value),
    .evicted       (evicted),
    .mismatch_count(err_count),
    .pending_count (pending)
  );

  // reply-side backpressure
  always @(negedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 11);
    out_stall <= (stall_left != 0);
    if (stall_left > 0) stall_left = stall_left - 1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic c, input logic [31:0] k, input logic [31:0] v);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    cmd         <= c;
    lookup_key  <= k;
    write_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_request();
    int          pick;
    logic [31:0] k;
    logic        c;
    pick = $urandom_range(0, 9);
    if (pick < 7) k = hot_keys[$urandom_range(0, 11)];
    else if (pick < 9) k = warm_keys[$urandom_range(0, 31)];
    else k = $urandom;
    c = ($urandom_range(0, 1) == 0) ? lrukv_pkg::CMD_GET : lrukv_pkg::CMD_PUT;
    send_request(c, k, $urandom);
  endtask

  initial begin
    hot_keys[0] = 32'h0000_0000;
    hot_keys[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) hot_keys[i] = $urandom;
    for (int i = 0; i < 32; i++) warm_keys[i] = $urandom;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: empty miss, extremes, hit, update, fill, evict
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lrukv_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lrukv_pkg::CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    for (int i = 1; i <= 6; i++) send_request(lrukv_pkg::CMD_PUT, 32'(i), ~32'(i));
    send_request(lrukv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0003, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_PUT, 32'h0000_0007, 32'hA5A5_A5A5);
    send_request(lrukv_pkg::CMD_PUT, 32'h0000_0008, 32'h5A5A_5A5A);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lrukv_pkg::CMD_PUT, 32'h8000_0000, 32'h8000_0001);
    send_request(lrukv_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = !((n >= 700 && n < 950) || n >= RANDOM_ITEMS - 300);
      if (n == 1100) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      random_request();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lrukv_pkg.sv
src/lrukv_cell.sv
src/lru_key_value_cache_unit.sv
tb/lru_cache_checker.sv
tb/tb.sv
